@@ src/mcm_pkg.sv @@
package mcm_pkg;

  // fixed field widths of the channels
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COL_W  = 2;

  // defaults for the top-level parameters
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL  = 1'b1;

  // one request: a column of four elements
  typedef struct packed {
    logic                     opcode;
    logic [COL_W-1:0]         column;
    logic signed [DATA_W-1:0] elem0;
    logic signed [DATA_W-1:0] elem1;
    logic signed [DATA_W-1:0] elem2;
    logic signed [DATA_W-1:0] elem3;
  } req_t;

  // one result: a product column
  typedef struct packed {
    logic [COL_W-1:0]         out_column;
    logic signed [DATA_W-1:0] res0;
    logic signed [DATA_W-1:0] res1;
    logic signed [DATA_W-1:0] res2;
    logic signed [DATA_W-1:0] res3;
    logic                     saturated;
  } result_t;

  // control that travels with the data through the pipeline
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] column;
  } tag_t;

endpackage

@@ src/mat4_column_multiply.sv @@
// channel  valid         ready         payload
// request  req_valid     req_ready     req     (mcm_pkg::req_t)
// result   result_valid  result_ready  result  (mcm_pkg::result_t)
//
// One request accepted per cycle unless a result is held; a multiply result
// passes through the input register, the multiplier register, two adder
// levels and the shift/clip output register.
// Load requests update the left matrix and produce no result.
// Reset clears all valid bits and sets the left matrix to identity.
// When a result waits unaccepted, all stages hold and req_ready drops.
module mat4_column_multiply #(
  parameter int unsigned FRAC_BITS  = mcm_pkg::FRAC_BITS_DEF,
  parameter int unsigned ELEM_WIDTH = mcm_pkg::ELEM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  mcm_pkg::req_t     req,
  output logic              result_valid,
  input  logic              result_ready,
  output mcm_pkg::result_t  result
);

  logic                           advance;
  mcm_pkg::tag_t                  s1_tag;
  logic                           s1_opcode;
  logic signed [ELEM_WIDTH-1:0]   s1_elem [4];
  mcm_pkg::tag_t                  s2_tag;
  logic signed [2*ELEM_WIDTH-1:0] s2_prod [16];
  mcm_pkg::tag_t                  s4_tag;
  logic signed [2*ELEM_WIDTH+1:0] s4_sum  [4];

  // whole pipeline moves unless a finished result is held
  assign advance   = !result_valid || result_ready;
  assign req_ready = advance;

  // input register, elements narrowed to the element width
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else if (advance) begin
      s1_tag.valid <= req_valid;
    end
    if (advance) begin
      s1_tag.column <= req.column;
      s1_opcode     <= req.opcode;
      s1_elem[0]    <= req.elem0[ELEM_WIDTH-1:0];
      s1_elem[1]    <= req.elem1[ELEM_WIDTH-1:0];
      s1_elem[2]    <= req.elem2[ELEM_WIDTH-1:0];
      s1_elem[3]    <= req.elem3[ELEM_WIDTH-1:0];
    end
  end

  mcm_mul_stage #(
    .FRAC_BITS  (FRAC_BITS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (s1_tag),
    .opcode  (s1_opcode),
    .elem    (s1_elem),
    .tag_out (s2_tag),
    .prod    (s2_prod)
  );

  mcm_sum_stage #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_sum (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (s2_tag),
    .prod    (s2_prod),
    .tag_out (s4_tag),
    .sum     (s4_sum)
  );

  mcm_sat_stage #(
    .FRAC_BITS  (FRAC_BITS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_sat (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (s4_tag),
    .sum     (s4_sum),
    .valid   (result_valid),
    .result  (result)
  );

endmodule

@@ src/mcm_mul_stage.sv @@
module mcm_mul_stage #(
  parameter int unsigned FRAC_BITS  = mcm_pkg::FRAC_BITS_DEF,
  parameter int unsigned ELEM_WIDTH = mcm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  mcm_pkg::tag_t                  tag_in,
  input  logic                           opcode,
  input  logic signed [ELEM_WIDTH-1:0]   elem [4],
  output mcm_pkg::tag_t                  tag_out,
  output logic signed [2*ELEM_WIDTH-1:0] prod [16]
);

  localparam logic [ELEM_WIDTH-1:0] EL_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] ONE_VAL =
    (FRAC_BITS >= ELEM_WIDTH - 1) ? EL_MAX
                                  : ({{(ELEM_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS);

  // left matrix, column-major: entry column*4+row
  logic signed [ELEM_WIDTH-1:0] lm [16];

  logic load_en;
  logic mul_en;

  assign load_en = advance && tag_in.valid && (opcode == mcm_pkg::OP_LOAD);
  assign mul_en  = tag_in.valid && (opcode == mcm_pkg::OP_MUL);

  // column load, applied in request order with the multiplies
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        lm[i] <= (i % 5 == 0) ? ONE_VAL : '0;
      end
    end else if (load_en) begin
      for (int k = 0; k < 4; k++) begin
        lm[{tag_in.column, 2'(k)}] <= elem[k];
      end
    end
  end

  // valid travels only for multiply requests
  // sixteen products, index row*4+k = left(row,k) * elem k
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (advance) begin
      tag_out.valid <= mul_en;
    end
    if (advance) begin
      tag_out.column <= tag_in.column;
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          prod[r*4+k] <= lm[k*4+r] * elem[k];
        end
      end
    end
  end

endmodule

@@ src/mcm_sum_stage.sv @@
module mcm_sum_stage #(
  parameter int unsigned ELEM_WIDTH = mcm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  mcm_pkg::tag_t                    tag_in,
  input  logic signed [2*ELEM_WIDTH-1:0]   prod [16],
  output mcm_pkg::tag_t                    tag_out,
  output logic signed [2*ELEM_WIDTH+1:0]   sum [4]
);

  localparam int unsigned PW  = 2 * ELEM_WIDTH;
  localparam int unsigned HW  = PW + 1;
  localparam int unsigned SW  = PW + 2;

  mcm_pkg::tag_t           tag_mid;
  logic signed [HW-1:0]    half [8];

  // first level: pairs of products
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_mid.valid <= 1'b0;
    end else if (advance) begin
      tag_mid.valid <= tag_in.valid;
    end
    if (advance) begin
      tag_mid.column <= tag_in.column;
      for (int r = 0; r < 4; r++) begin
        half[r*2]   <= HW'(prod[r*4])   + HW'(prod[r*4+1]);
        half[r*2+1] <= HW'(prod[r*4+2]) + HW'(prod[r*4+3]);
      end
    end
  end

  // second level: full row sums, exact
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (advance) begin
      tag_out.valid <= tag_mid.valid;
    end
    if (advance) begin
      tag_out.column <= tag_mid.column;
      for (int r = 0; r < 4; r++) begin
        sum[r] <= SW'(half[r*2]) + SW'(half[r*2+1]);
      end
    end
  end

endmodule

@@ src/mcm_sat_stage.sv @@
module mcm_sat_stage #(
  parameter int unsigned FRAC_BITS  = mcm_pkg::FRAC_BITS_DEF,
  parameter int unsigned ELEM_WIDTH = mcm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  mcm_pkg::tag_t                  tag_in,
  input  logic signed [2*ELEM_WIDTH+1:0] sum [4],
  output logic                           valid,
  output mcm_pkg::result_t               result
);

  localparam int unsigned SW = 2 * ELEM_WIDTH + 2;
  localparam logic [ELEM_WIDTH-1:0] EL_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] EL_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  logic signed [SW-1:0]              shifted [4];
  logic signed [ELEM_WIDTH-1:0]      clip    [4];
  logic signed [mcm_pkg::DATA_W-1:0] wide    [4];
  logic [3:0]                        over;

  // floor shift, then clip to the element range
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      shifted[r] = sum[r] >>> FRAC_BITS;
      over[r]    = !((&shifted[r][SW-1:ELEM_WIDTH-1]) || !(|shifted[r][SW-1:ELEM_WIDTH-1]));
      if (over[r]) begin
        clip[r] = shifted[r][SW-1] ? EL_MIN : EL_MAX;
      end else begin
        clip[r] = shifted[r][ELEM_WIDTH-1:0];
      end
      wide[r] = mcm_pkg::DATA_W'(clip[r]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_column <= tag_in.column;
      result.res0       <= wide[0];
      result.res1       <= wide[1];
      result.res2       <= wide[2];
      result.res3       <= wide[3];
      result.saturated  <= |over;
    end
  end

endmodule

@@ tb/tb_mat4_column_multiply.sv @@
`timescale 1ns / 100ps

module tb_mat4_column_multiply;

  localparam int unsigned FRAC        = mcm_pkg::FRAC_BITS_DEF;
  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          DRAIN_LIMIT = 2_000;
  localparam int          RANDOM_REQS = 1_000;

  localparam logic signed [mcm_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [mcm_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mcm_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [127:0]      WIDE_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0]      WIDE_MIN = -128'sh8000_0000;

  // tracks the left matrix and the product columns still owed by the block
  class product_scoreboard;
    logic signed [mcm_pkg::DATA_W-1:0] left_cols [16];
    mcm_pkg::result_t pending_columns [$];
    int errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        left_cols[i] = (i % 5 == 0) ? Q_ONE : '0;
      end
      errors = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // exact sum of four products, floor shift, clip to 32 bits
    function mcm_pkg::result_t column_product(input mcm_pkg::req_t r);
      logic signed [mcm_pkg::DATA_W-1:0] e [4];
      logic signed [mcm_pkg::DATA_W-1:0] row_val [4];
      logic signed [127:0] a, b, acc, scaled;
      logic clipped;
      mcm_pkg::result_t p;
      e[0] = r.elem0;
      e[1] = r.elem1;
      e[2] = r.elem2;
      e[3] = r.elem3;
      clipped = 1'b0;
      for (int row = 0; row < 4; row++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          a = left_cols[k*4 + row];
          b = e[k];
          acc = acc + a * b;
        end
        scaled = acc >>> FRAC;
        if (scaled > WIDE_MAX) begin
          row_val[row] = Q_MAX;
          clipped = 1'b1;
        end else if (scaled < WIDE_MIN) begin
          row_val[row] = Q_MIN;
          clipped = 1'b1;
        end else begin
          row_val[row] = scaled[mcm_pkg::DATA_W-1:0];
        end
      end
      p.out_column = r.column;
      p.res0       = row_val[0];
      p.res1       = row_val[1];
      p.res2       = row_val[2];
      p.res3       = row_val[3];
      p.saturated  = clipped;
      return p;
    endfunction

    // accepted request: load a column or queue the product column
    function void note_request(input mcm_pkg::req_t r);
      int base;
      base = r.column * 4;
      if (r.opcode == mcm_pkg::OP_LOAD) begin
        left_cols[base]     = r.elem0;
        left_cols[base + 1] = r.elem1;
        left_cols[base + 2] = r.elem2;
        left_cols[base + 3] = r.elem3;
      end else begin
        pending_columns.push_back(column_product(r));
      end
    endfunction

    // accepted result against the oldest owed column
    task check_result(input mcm_pkg::result_t got);
      mcm_pkg::result_t want;
      if (pending_columns.size() == 0) begin
        report($sformatf("unexpected result for column %0d", got.out_column));
      end else begin
        want = pending_columns.pop_front();
        if (got.out_column !== want.out_column)
          report($sformatf("out_column got %0d want %0d", got.out_column, want.out_column));
        if (got.res0 !== want.res0)
          report($sformatf("res0 got %h want %h", got.res0, want.res0));
        if (got.res1 !== want.res1)
          report($sformatf("res1 got %h want %h", got.res1, want.res1));
        if (got.res2 !== want.res2)
          report($sformatf("res2 got %h want %h", got.res2, want.res2));
        if (got.res3 !== want.res3)
          report($sformatf("res3 got %h want %h", got.res3, want.res3));
        if (got.saturated !== want.saturated)
          report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
      end
    endtask
  endclass

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             req_valid    = 1'b0;
  logic             req_ready;
  mcm_pkg::req_t    req          = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  mcm_pkg::result_t result;

  logic    steady = 1'b0;
  int      cycle_count = 0;
  product_scoreboard sb = new();

  mat4_column_multiply dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 18);
  end

  // accepted requests and results
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      sb.note_request(req);
    end
    if (!rst && result_valid && result_ready) begin
      sb.check_result(result);
    end
  end

  // element values spread over small, medium, extreme and full range
  function automatic logic [mcm_pkg::DATA_W-1:0] random_elem();
    logic [mcm_pkg::DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: v = {{13{v[19]}}, v[18:0]};
      4, 5:       v = {{8{v[23]}}, v[23:0]};
      6: begin
        case ($urandom_range(4))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          3:       v = '1;
          default: v = Q_ONE;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // one request, with a random gap before it; returns at a falling edge
  task automatic send(input logic op, input logic [mcm_pkg::COL_W-1:0] col,
                      input logic [mcm_pkg::DATA_W-1:0] e0,
                      input logic [mcm_pkg::DATA_W-1:0] e1,
                      input logic [mcm_pkg::DATA_W-1:0] e2,
                      input logic [mcm_pkg::DATA_W-1:0] e3);
    mcm_pkg::req_t r;
    r.opcode = op;
    r.column = col;
    r.elem0  = e0;
    r.elem1  = e1;
    r.elem2  = e2;
    r.elem3  = e3;
    while (!steady && $urandom_range(99) < 18) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  initial begin
    int wait_count;
    logic op;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity after reset, extremes pass straight through
    send(mcm_pkg::OP_MUL, 2'd0, Q_ONE, 32'sh0002_0000, '1, Q_MAX);
    send(mcm_pkg::OP_MUL, 2'd3, Q_MIN, '0, 32'sd1, -32'sh0001_0000);
    send(mcm_pkg::OP_MUL, 2'd1, '1, '1, '1, '1);

    // extreme left matrix
    send(mcm_pkg::OP_LOAD, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send(mcm_pkg::OP_LOAD, 2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send(mcm_pkg::OP_LOAD, 2'd2, 32'sd1, '1, Q_MAX, Q_MIN);
    send(mcm_pkg::OP_LOAD, 2'd3, '0, '0, '0, '0);

    // positive and negative clipping, min times min
    send(mcm_pkg::OP_MUL, 2'd0, Q_MAX, '0, '0, '0);
    send(mcm_pkg::OP_MUL, 2'd1, '0, Q_MIN, '0, '0);
    send(mcm_pkg::OP_MUL, 2'd2, '0, Q_MAX, '0, '0);
    // large products cancel in the exact sum
    send(mcm_pkg::OP_MUL, 2'd3, Q_MAX, Q_MAX, '0, '0);
    // floor of tiny positive and negative products
    send(mcm_pkg::OP_MUL, 2'd0, '0, '0, 32'sd1, '0);
    send(mcm_pkg::OP_MUL, 2'd1, '0, '0, '1, Q_MAX);
    send(mcm_pkg::OP_MUL, 2'd2, Q_MIN, Q_MIN, Q_MIN, Q_MIN);

    // small matrix, exact fractional results
    send(mcm_pkg::OP_LOAD, 2'd0, 32'sh0000_8000, -32'sh0001_8000, 32'sd3, '0);
    send(mcm_pkg::OP_LOAD, 2'd1, '0, Q_ONE, '0, -32'sh0000_4000);
    send(mcm_pkg::OP_LOAD, 2'd2, 32'sh0003_0000, '0, Q_ONE, 32'sd7);
    send(mcm_pkg::OP_LOAD, 2'd3, '1, 32'sh0000_0100, '0, Q_ONE);
    send(mcm_pkg::OP_MUL, 2'd0, 32'sh0001_8000, -32'sh0000_0003, 32'sh0000_FFFF, Q_ONE);
    send(mcm_pkg::OP_MUL, 2'd3, -32'sh0002_0000, Q_ONE, '1, 32'sd5);
    send(mcm_pkg::OP_MUL, 2'd2, Q_MAX, Q_MIN, '0, '1);

    // random traffic, with one stretch free of gaps and stalls
    for (int n = 0; n < RANDOM_REQS; n++) begin
      steady = (n >= 400 && n < 600);
      op = ($urandom_range(9) < 3) ? mcm_pkg::OP_LOAD : mcm_pkg::OP_MUL;
      send(op, mcm_pkg::COL_W'($urandom_range(3)), random_elem(), random_elem(),
           random_elem(), random_elem());
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    // drain owed results, then watch for strays
    wait_count = 0;
    while (sb.pending_columns.size() != 0 && wait_count < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (12) @(posedge clk);
    if (sb.pending_columns.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending_columns.size()));
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
